>>> sv/cra_pkg.sv
package cra_pkg;

  // Field widths of the stream and configuration ports
  localparam int CMD_W      = 1;
  localparam int REQ_W      = 19;
  localparam int FH_W       = 6;
  localparam int CB_W       = 13;
  localparam int STATUS_W   = 2;
  localparam int HEAD_W     = 6;
  localparam int COUNT_W    = 7;
  localparam int S_TDATA_W  = 32;
  localparam int M_TDATA_W  = 24;

  // Rounded-up request: request_bytes + chunk_bytes - 1 needs one more bit
  localparam int QUO_W      = REQ_W + 1;

  localparam logic [CB_W-1:0] CB_RESET = 13'd128;

  typedef enum logic [STATUS_W-1:0] {
    RES_OK      = 2'd0,
    RES_NOFIT   = 2'd1,
    RES_BADFREE = 2'd2
  } res_code_t;

  // Controller to datapath
  typedef struct packed {
    logic      take;
    logic      rd_free;
    logic      walk_init;
    logic      walk_jump;
    logic      walk_step;
    logic      walk_scan;
    logic      sweep_alloc;
    logic      sweep_free;
    logic      sweep_wr;
    logic      commit_alloc;
    logic      commit_free;
    logic      res_set;
    res_code_t res_code;
    logic      out_load;
  } cra_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_done;
    logic need_too_big;
    logic stp_done;
    logic p_eq_s;
    logic s_at_end;
    logic span_ok;
    logic rd_busy;
    logic free_bad;
    logic sweep_last;
    logic out_free;
  } cra_sts_t;

endpackage

>>> sv/chunk_run_allocator_unit.sv
// Next-fit chunk pool allocator over NUM_CHUNKS chunks of chunk_bytes bytes.
// One input beat is one request and gives exactly one result beat. After
// reset the block runs a clearing pass over every entry of the run store
// with s_axis_tready low; configuration writes are taken meanwhile.
// Requests are handled one at a time. An allocate runs a bit-serial divide
// for the round-up, then W walk actions (each a registered read of the run
// store and an evaluation; W is at most NUM_CHUNKS walk steps plus the scan
// advances that check a candidate span, one chunk per action), then marks
// the run chunk by chunk. A free does one store read, then, if the head is
// valid, releases the run chunk by chunk. The next beat is accepted as soon
// as the result is in the output register, even if the sink has not taken
// it yet.
module chunk_run_allocator_unit #(
  parameter int NUM_CHUNKS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration: chunk_bytes
  input  logic                          cfg_wr_en,
  input  logic [cra_pkg::CB_W-1:0]      cfg_wr_data,
  // request stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [18:0] request_bytes, [24:19] free_head, [31:25] zero
  input  logic [cra_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // [0] cmd (0 allocate, 1 free)
  input  logic [cra_pkg::CMD_W-1:0]     s_axis_tuser,
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [5:0] head_chunk, [12:6] live_objects, [19:13] used_chunks, [23:20] zero
  output logic [cra_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // [1:0] status (0 ok, 1 no fit, 2 bad free)
  output logic [cra_pkg::STATUS_W-1:0]  m_axis_tuser
);

  localparam int REQ_LO  = 0;
  localparam int FH_LO   = REQ_LO + cra_pkg::REQ_W;
  localparam int LIVE_LO = cra_pkg::HEAD_W;
  localparam int USED_LO = LIVE_LO + cra_pkg::COUNT_W;
  localparam int M_USED  = USED_LO + cra_pkg::COUNT_W;

  cra_pkg::cra_cmd_t cmd;
  cra_pkg::cra_sts_t sts;

  logic [cra_pkg::HEAD_W-1:0]  head_chunk;
  logic [cra_pkg::COUNT_W-1:0] live_objects;
  logic [cra_pkg::COUNT_W-1:0] used_chunks;

  cra_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_axis_tvalid),
    .item_free (s_axis_tuser[0]),
    .sts       (sts),
    .s_tready  (s_axis_tready),
    .cmd       (cmd)
  );

  cra_dp #(
    .NUM_CHUNKS (NUM_CHUNKS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .request_bytes (s_axis_tdata[FH_LO-1:REQ_LO]),
    .free_head     (s_axis_tdata[FH_LO+cra_pkg::FH_W-1:FH_LO]),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .status        (m_axis_tuser),
    .head_chunk    (head_chunk),
    .live_objects  (live_objects),
    .used_chunks   (used_chunks)
  );

  assign m_axis_tdata = {{(cra_pkg::M_TDATA_W - M_USED){1'b0}},
                         used_chunks, live_objects, head_chunk};

endmodule

>>> sv/cra_div.sv
// Restoring divider, one quotient bit per cycle.
module cra_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [cra_pkg::QUO_W-1:0] dividend,
  input  logic [cra_pkg::CB_W-1:0]  divisor,
  output logic                      done,
  output logic [cra_pkg::QUO_W-1:0] quotient
);

  localparam int QW     = cra_pkg::QUO_W;
  localparam int DW     = cra_pkg::CB_W;
  localparam int ITER_W = $clog2(QW);

  logic [DW-1:0]     dvs;
  logic [DW-1:0]     rem;
  logic [DW-1:0]     rem_next;
  logic [QW-1:0]     quo;
  logic [ITER_W-1:0] cnt;
  logic              busy;
  logic [DW:0]       trial;
  logic [DW:0]       diff;
  logic              ge;

  always_comb begin
    trial    = {rem, quo[QW-1]};
    diff     = trial - {1'b0, dvs};
    ge       = (trial >= {1'b0, dvs});
    rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= ITER_W'(QW - 1);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        cnt <= cnt - ITER_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[QW-2:0], ge};
    end
  end

  assign quotient = quo;

endmodule

>>> sv/cra_dp.sv
// Datapath: run store, walk pointers, sweep counter, counts and result beat.
module cra_dp #(
  parameter int NUM_CHUNKS = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  cra_pkg::cra_cmd_t            cmd,
  output cra_pkg::cra_sts_t            sts,
  input  logic [cra_pkg::REQ_W-1:0]    request_bytes,
  input  logic [cra_pkg::FH_W-1:0]     free_head,
  input  logic                         cfg_wr_en,
  input  logic [cra_pkg::CB_W-1:0]     cfg_wr_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [cra_pkg::STATUS_W-1:0] status,
  output logic [cra_pkg::HEAD_W-1:0]   head_chunk,
  output logic [cra_pkg::COUNT_W-1:0]  live_objects,
  output logic [cra_pkg::COUNT_W-1:0]  used_chunks
);

  localparam int IDX_W = $clog2(NUM_CHUNKS);
  localparam int PTR_W = IDX_W + 1;
  localparam int CNT_W = $clog2(NUM_CHUNKS + 1);
  localparam int ENT_W = CNT_W + 1;
  localparam logic [PTR_W-1:0] N_PTR = PTR_W'(NUM_CHUNKS);
  localparam logic [CNT_W-1:0] N_CNT = CNT_W'(NUM_CHUNKS);

  // entry = {busy, run length at a head (0 elsewhere)}
  logic [ENT_W-1:0] mem [NUM_CHUNKS];
  logic [ENT_W-1:0] rd_q;

  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] sw_addr;
  logic [IDX_W-1:0] sw_base;
  logic [IDX_W-1:0] p;
  logic [IDX_W-1:0] cursor;
  logic [IDX_W-1:0] jump_p;
  logic [IDX_W-1:0] step_p;
  logic [PTR_W-1:0] s;
  logic [PTR_W-1:0] step_sum;
  logic [PTR_W:0]   jump_sum;
  logic             step_wrap;
  logic [CNT_W-1:0] stp;
  logic [CNT_W-1:0] need;
  logic [CNT_W-1:0] need_calc;
  logic [CNT_W-1:0] obj;
  logic [CNT_W-1:0] used;
  logic [CNT_W-1:0] sw_k;
  logic [CNT_W-1:0] sw_len;
  logic [CNT_W-1:0] rd_len;
  logic [CNT_W-1:0] jump_by;
  logic [CNT_W-1:0] wr_len;
  logic [CNT_W:0]   sw_sum;
  logic             sw_set;
  logic             rd_busy;

  logic [cra_pkg::CB_W-1:0]  cb;
  logic [cra_pkg::CB_W-1:0]  cb_eff;
  logic [cra_pkg::QUO_W-1:0] dividend;
  logic [cra_pkg::QUO_W-1:0] quo;
  logic                      div_done;
  logic [cra_pkg::FH_W-1:0]  fh;
  logic                      fh_oob;

  cra_pkg::res_code_t          res_code;
  logic [cra_pkg::HEAD_W-1:0]  res_head;
  cra_pkg::res_code_t          o_code;

  // chunk size register
  always_ff @(posedge clk) begin
    if (rst) begin
      cb <= cra_pkg::CB_RESET;
    end else if (cfg_wr_en) begin
      cb <= cfg_wr_data;
    end
  end

  assign cb_eff   = (cb == '0) ? cra_pkg::CB_W'(1) : cb;
  assign dividend = cra_pkg::QUO_W'(request_bytes) + cra_pkg::QUO_W'(cb_eff)
                    - cra_pkg::QUO_W'(1);

  cra_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.take),
    .dividend (dividend),
    .divisor  (cb_eff),
    .done     (div_done),
    .quotient (quo)
  );

  assign need_calc = (quo == '0) ? CNT_W'(1) : CNT_W'(quo);

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      fh <= free_head;
    end
  end

  assign fh_oob = (32'(fh) >= 32'(NUM_CHUNKS));

  // run store
  assign rd_addr = cmd.rd_free ? IDX_W'(fh) : s[IDX_W-1:0];
  assign sw_sum  = (CNT_W + 1)'(sw_base) + (CNT_W + 1)'(sw_k);
  assign sw_addr = IDX_W'(sw_sum);
  assign wr_len  = (sw_set && sw_k == '0) ? need : '0;

  always_ff @(posedge clk) begin
    if (cmd.sweep_wr) begin
      mem[sw_addr] <= {sw_set, wr_len};
    end
    rd_q <= mem[rd_addr];
  end

  assign rd_busy = rd_q[ENT_W-1];
  assign rd_len  = rd_q[CNT_W-1:0];

  // next positions of the walk
  always_comb begin
    jump_by   = (rd_len == '0) ? CNT_W'(1) : rd_len;
    jump_sum  = (PTR_W + 1)'(p) + (PTR_W + 1)'(jump_by);
    jump_p    = (jump_sum >= (PTR_W + 1)'(NUM_CHUNKS)) ? '0 : IDX_W'(jump_sum);
    step_sum  = PTR_W'(p) + PTR_W'(1);
    step_wrap = (step_sum == N_PTR);
    step_p    = step_wrap ? '0 : IDX_W'(step_sum);
  end

  // p: walk position, s: scan edge ([p, s) known free), stp: walk steps
  always_ff @(posedge clk) begin
    if (cmd.walk_init) begin
      p    <= cursor;
      s    <= PTR_W'(cursor);
      stp  <= '0;
      need <= need_calc;
    end else if (cmd.walk_jump) begin
      p   <= jump_p;
      s   <= PTR_W'(jump_p);
      stp <= stp + CNT_W'(1);
    end else if (cmd.walk_step) begin
      p   <= step_p;
      s   <= step_wrap ? '0 : s;
      stp <= stp + CNT_W'(1);
    end else if (cmd.walk_scan) begin
      s <= s + PTR_W'(1);
    end
  end

  // sweep counter; reset values set up the clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      sw_base <= '0;
      sw_k    <= '0;
      sw_len  <= N_CNT;
      sw_set  <= 1'b0;
    end else if (cmd.sweep_alloc) begin
      sw_base <= p;
      sw_k    <= '0;
      sw_len  <= need;
      sw_set  <= 1'b1;
    end else if (cmd.sweep_free) begin
      sw_base <= IDX_W'(fh);
      sw_k    <= '0;
      sw_len  <= rd_len;
      sw_set  <= 1'b0;
    end else if (cmd.sweep_wr) begin
      sw_k <= sw_k + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor <= '0;
      obj    <= '0;
      used   <= '0;
    end else if (cmd.commit_alloc) begin
      cursor <= p;
      obj    <= obj + CNT_W'(1);
      used   <= used + need;
    end else if (cmd.commit_free) begin
      obj  <= obj - CNT_W'(1);
      used <= used - sw_len;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_set) begin
      res_code <= cmd.res_code;
      if (cmd.commit_alloc) begin
        res_head <= cra_pkg::HEAD_W'(p);
      end else if (cmd.res_code == cra_pkg::RES_NOFIT) begin
        res_head <= '0;
      end else begin
        res_head <= cra_pkg::HEAD_W'(fh);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      o_code       <= res_code;
      head_chunk   <= res_head;
      live_objects <= cra_pkg::COUNT_W'(obj);
      used_chunks  <= cra_pkg::COUNT_W'(used);
    end
  end

  assign status = o_code;

  always_comb begin
    sts.div_done     = div_done;
    sts.need_too_big = (quo > cra_pkg::QUO_W'(NUM_CHUNKS));
    sts.stp_done     = (stp == N_CNT);
    sts.p_eq_s       = (PTR_W'(p) == s);
    sts.s_at_end     = (s == N_PTR);
    sts.span_ok      = ((s - PTR_W'(p)) >= PTR_W'(need));
    sts.rd_busy      = rd_busy;
    sts.free_bad     = fh_oob || (rd_len == '0);
    sts.sweep_last   = ((sw_k + CNT_W'(1)) == sw_len);
    sts.out_free     = !out_valid || out_ready;
  end

  a_walk_order: assert property (@(posedge clk) disable iff (rst)
    (cmd.walk_jump || cmd.walk_step || cmd.walk_scan) |-> (PTR_W'(p) <= s))
    else $error("walk position passed the scan edge");

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= N_CNT)
    else $error("used chunk count exceeds the pool");

  a_obj_le_used: assert property (@(posedge clk) disable iff (rst)
    obj <= used)
    else $error("more live runs than used chunks");

endmodule

>>> sv/cra_ctrl.sv
// Sequencer: clearing pass, divide, run walk, mark/unmark sweeps, result.
module cra_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              item_free,
  input  cra_pkg::cra_sts_t sts,
  output logic              s_tready,
  output cra_pkg::cra_cmd_t cmd
);

  typedef enum logic [9:0] {
    S_CLEAR   = 10'b0000000001,
    S_IDLE    = 10'b0000000010,
    S_DIV     = 10'b0000000100,
    S_WALK_RD = 10'b0000001000,
    S_WALK_EV = 10'b0000010000,
    S_MARK    = 10'b0000100000,
    S_FREE_RD = 10'b0001000000,
    S_FREE_EV = 10'b0010000000,
    S_UNMARK  = 10'b0100000000,
    S_DONE    = 10'b1000000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.sweep_wr = 1'b1;
        if (sts.sweep_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.take   = 1'b1;
          state_next = item_free ? S_FREE_RD : S_DIV;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          if (sts.need_too_big) begin
            cmd.res_set  = 1'b1;
            cmd.res_code = cra_pkg::RES_NOFIT;
            state_next   = S_DONE;
          end else begin
            cmd.walk_init = 1'b1;
            state_next    = S_WALK_RD;
          end
        end
      end
      S_WALK_RD: begin
        state_next = S_WALK_EV;
      end
      S_WALK_EV: begin
        state_next = S_WALK_RD;
        if (sts.stp_done) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = cra_pkg::RES_NOFIT;
          state_next   = S_DONE;
        end else if (sts.p_eq_s) begin
          if (sts.rd_busy) begin
            cmd.walk_jump = 1'b1;
          end else begin
            cmd.walk_scan = 1'b1;
          end
        end else if (sts.span_ok) begin
          cmd.sweep_alloc = 1'b1;
          state_next      = S_MARK;
        end else if (sts.s_at_end || sts.rd_busy) begin
          cmd.walk_step = 1'b1;
        end else begin
          cmd.walk_scan = 1'b1;
        end
      end
      S_MARK: begin
        cmd.sweep_wr = 1'b1;
        if (sts.sweep_last) begin
          cmd.commit_alloc = 1'b1;
          cmd.res_set      = 1'b1;
          cmd.res_code     = cra_pkg::RES_OK;
          state_next       = S_DONE;
        end
      end
      S_FREE_RD: begin
        cmd.rd_free = 1'b1;
        state_next  = S_FREE_EV;
      end
      S_FREE_EV: begin
        if (sts.free_bad) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = cra_pkg::RES_BADFREE;
          state_next   = S_DONE;
        end else begin
          cmd.sweep_free = 1'b1;
          state_next     = S_UNMARK;
        end
      end
      S_UNMARK: begin
        cmd.sweep_wr = 1'b1;
        if (sts.sweep_last) begin
          cmd.commit_free = 1'b1;
          cmd.res_set     = 1'b1;
          cmd.res_code    = cra_pkg::RES_OK;
          state_next      = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    cmd.take |=> !s_tready)
    else $error("input taken again before the request finished");

endmodule

>>> tb/chunk_run_allocator_unit_tb.sv
module chunk_run_allocator_unit_tb;

  localparam int CMD_W     = cra_pkg::CMD_W;
  localparam int REQ_W     = cra_pkg::REQ_W;
  localparam int FH_W      = cra_pkg::FH_W;
  localparam int CB_W      = cra_pkg::CB_W;
  localparam int STATUS_W  = cra_pkg::STATUS_W;
  localparam int HEAD_W    = cra_pkg::HEAD_W;
  localparam int COUNT_W   = cra_pkg::COUNT_W;
  localparam int S_TDATA_W = cra_pkg::S_TDATA_W;
  localparam int M_TDATA_W = cra_pkg::M_TDATA_W;

  localparam int NUM_CHUNKS = 64;
  // Slowest allocate: divide, then up to NUM_CHUNKS walk steps plus about two
  // pool lengths of scan advances, each action a store read and an evaluation,
  // then the mark sweep.
  // Add a sink that stalls 77% of the time and keep a wide margin.
  localparam int STALL_LIMIT = 40000;
  // Quiet cycles before a chunk size write, and at the very end.
  localparam int IDLE_GAP = 8;
  localparam int SETTLE_CYCLES = 200;
  localparam logic [REQ_W-1:0] REQ_MAX = '1;

  typedef enum logic [CMD_W-1:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  // One expected result beat
  typedef struct {
    cra_pkg::res_code_t status;
    logic [HEAD_W-1:0]  head;
    logic [COUNT_W-1:0] live;
    logic [COUNT_W-1:0] used;
  } pool_result_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 cfg_wr_en = 1'b0;
  logic [CB_W-1:0]      cfg_wr_data = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic [CMD_W-1:0]     s_axis_tuser = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0]  m_axis_tuser;

  chunk_run_allocator_unit #(
    .NUM_CHUNKS(NUM_CHUNKS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Shadow pool: run length per head, busy flag per chunk, next-fit cursor
  logic [COUNT_W-1:0] run_len [NUM_CHUNKS];
  bit                 chunk_taken [NUM_CHUNKS];
  int unsigned        cursor;
  int unsigned        live_runs;
  int unsigned        used_total;
  logic [CB_W-1:0]    chunk_sz;
  pool_result_t       pending_results[$];

  int src_idle_pct  = 0;
  int sink_idle_pct = 0;
  int fail_count    = 0;
  int quiet_cycles  = 0;

  task automatic report_fail(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    fail_count++;
  endtask

  // Apply one request to the shadow pool and return the result it gives.
  function automatic pool_result_t predict_request(input op_t op,
                                                   input logic [REQ_W-1:0] bytes,
                                                   input logic [FH_W-1:0] fh);
    pool_result_t r;
    int unsigned  cb, need, p, len;
    bit           found, fits;
    r.status = cra_pkg::RES_OK;
    r.head   = '0;
    if (op == OP_ALLOC) begin
      cb   = (chunk_sz == 0) ? 1 : chunk_sz;   // zero chunk size acts as one byte
      need = (bytes + cb - 1) / cb;
      if (need == 0) need = 1;                 // empty request still takes a chunk
      found = 1'b0;
      if (need <= NUM_CHUNKS) begin
        p = cursor;
        for (int step = 0; step < NUM_CHUNKS && !found; step++) begin
          if (!chunk_taken[p]) begin
            // candidate must be all free and end inside the pool
            fits = (p + need <= NUM_CHUNKS);
            for (int i = 0; fits && i < need; i++)
              if (chunk_taken[p + i]) fits = 1'b0;
            if (fits) found = 1'b1;
            else p = (p + 1 >= NUM_CHUNKS) ? 0 : p + 1;
          end else begin
            // jump a whole run; a busy non-head moves one chunk
            len = (run_len[p] != 0) ? run_len[p] : 1;
            p = (p + len >= NUM_CHUNKS) ? 0 : p + len;
          end
        end
      end
      if (found) begin
        for (int i = 0; i < need; i++) chunk_taken[p + i] = 1'b1;
        run_len[p] = COUNT_W'(need);
        cursor     = p;
        live_runs++;
        used_total += need;
        r.head = HEAD_W'(p);
      end else begin
        r.status = cra_pkg::RES_NOFIT;
      end
    end else begin
      r.head = fh;
      if (run_len[fh] == 0) begin
        r.status = cra_pkg::RES_BADFREE;   // not a head, or already freed
      end else begin
        len = run_len[fh];
        for (int i = 0; i < len; i++) chunk_taken[fh + i] = 1'b0;
        run_len[fh] = '0;
        used_total -= len;
        live_runs--;
      end
    end
    r.live = live_runs[COUNT_W-1:0];
    r.used = used_total[COUNT_W-1:0];
    return r;
  endfunction

  // Random head of a live run, or -1 when the pool is empty
  function automatic int pick_live_head();
    int heads[$];
    foreach (run_len[k])
      if (run_len[k] != 0) heads.push_back(k);
    if (heads.size() == 0) return -1;
    return heads[$urandom_range(heads.size() - 1)];
  endfunction

  // Byte count that rounds up to exactly `need` chunks at the current size
  function automatic logic [REQ_W-1:0] bytes_for_chunks(input int unsigned need);
    int unsigned cb, b;
    cb = (chunk_sz == 0) ? 1 : chunk_sz;
    b  = (need - 1) * cb + $urandom_range(cb, 1);
    if (b > REQ_MAX) b = REQ_MAX;
    return b[REQ_W-1:0];
  endfunction

  // Observe config writes, accepted requests and accepted results at the edge.
  always @(posedge clk) begin : monitor
    pool_result_t got, want;
    if (rst) begin
      foreach (run_len[k]) begin
        run_len[k]     = '0;
        chunk_taken[k] = 1'b0;
      end
      cursor     = 0;
      live_runs  = 0;
      used_total = 0;
      chunk_sz   = cra_pkg::CB_RESET;
      pending_results.delete();
    end else begin
      if (cfg_wr_en) chunk_sz = cfg_wr_data;
      if (s_axis_tvalid && s_axis_tready)
        pending_results.push_back(predict_request(op_t'(s_axis_tuser),
                                                  s_axis_tdata[REQ_W-1:0],
                                                  s_axis_tdata[REQ_W +: FH_W]));
      if (m_axis_tvalid && m_axis_tready) begin
        got.status = cra_pkg::res_code_t'(m_axis_tuser);
        got.head   = m_axis_tdata[HEAD_W-1:0];
        got.live   = m_axis_tdata[HEAD_W +: COUNT_W];
        got.used   = m_axis_tdata[HEAD_W + COUNT_W +: COUNT_W];
        if (pending_results.size() == 0) begin
          report_fail($sformatf("result beat with nothing pending (status %0d head %0d)",
                                got.status, got.head));
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status)
            report_fail($sformatf("status got %0d exp %0d", got.status, want.status));
          if (got.head !== want.head)
            report_fail($sformatf("head_chunk got %0d exp %0d", got.head, want.head));
          if (got.live !== want.live)
            report_fail($sformatf("live_objects got %0d exp %0d", got.live, want.live));
          if (got.used !== want.used)
            report_fail($sformatf("used_chunks got %0d exp %0d", got.used, want.used));
        end
      end
    end
  end

  // Sink backpressure, redrawn each cycle
  always @(negedge clk)
    m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);

  // Watchdog: too long without a beat on either side means a hang
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  // tvalid stays high on return, so the caller must drive again in the same step.
  task automatic send_req(input op_t op, input logic [REQ_W-1:0] bytes,
                          input logic [FH_W-1:0] fh);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {{(S_TDATA_W - REQ_W - FH_W){1'b0}}, fh, bytes};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Hold off the source until every pending result has been taken
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_chunk_bytes(input logic [CB_W-1:0] value);
    drain_results();
    repeat (IDLE_GAP) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Reset chunk size of 128 bytes; pool starts empty
  task automatic test_directed();
    send_req(OP_FREE,  REQ_W'($urandom), 6'd5);   // free on a cleared store
    send_req(OP_ALLOC, 19'd0, FH_W'($urandom));   // zero bytes -> one chunk at 0
    send_req(OP_ALLOC, 19'd1, FH_W'($urandom));   // jump run at 0 -> head 1
    send_req(OP_ALLOC, 19'd128, FH_W'($urandom)); // exactly one chunk
    send_req(OP_ALLOC, 19'd129, FH_W'($urandom)); // rounds up to two chunks
    send_req(OP_ALLOC, REQ_MAX, FH_W'($urandom)); // far beyond pool size
    send_req(OP_ALLOC, 19'd8193, FH_W'($urandom)); // one chunk more than the pool
    send_req(OP_ALLOC, 19'd8192, FH_W'($urandom)); // whole pool, but some is taken
    send_req(OP_FREE,  REQ_W'($urandom), 6'd4);   // middle of a run, not a head
    send_req(OP_FREE,  REQ_MAX, 6'd3);
    send_req(OP_FREE,  REQ_W'($urandom), 6'd3);   // double free
    send_req(OP_FREE,  REQ_W'($urandom), 6'd63);  // never allocated
    send_req(OP_ALLOC, 19'd7680, FH_W'($urandom)); // 60 chunks, 3..62
    send_req(OP_ALLOC, 19'd256, FH_W'($urandom)); // two chunks only fit past the end
    send_req(OP_ALLOC, 19'd128, FH_W'($urandom)); // last chunk exactly
    send_req(OP_FREE,  REQ_W'($urandom), 6'd0);
    send_req(OP_FREE,  REQ_W'($urandom), 6'd1);
    send_req(OP_FREE,  REQ_W'($urandom), 6'd2);
    send_req(OP_ALLOC, 19'd384, FH_W'($urandom)); // cursor at 63 wraps to 0
    send_req(OP_FREE,  REQ_W'($urandom), 6'd63);
    send_req(OP_FREE,  REQ_W'($urandom), 6'd3);
    send_req(OP_FREE,  REQ_W'($urandom), 6'd0);
    send_req(OP_ALLOC, 19'd8192, FH_W'($urandom)); // whole pool from empty
    send_req(OP_ALLOC, 19'd0, FH_W'($urandom));   // pool full
    send_req(OP_FREE,  REQ_W'($urandom), 6'd0);
  endtask

  // Chunk size at zero, one, field max and range max
  task automatic test_chunk_size_extremes();
    logic [CB_W-1:0] sizes [4] = '{13'd0, 13'd1, 13'd8191, 13'd4096};
    int h;
    foreach (sizes[s]) begin
      write_chunk_bytes(sizes[s]);
      send_req(OP_ALLOC, 19'd0, FH_W'($urandom));
      send_req(OP_ALLOC, bytes_for_chunks(1), FH_W'($urandom));
      send_req(OP_ALLOC, REQ_MAX, FH_W'($urandom));
      send_req(OP_ALLOC, bytes_for_chunks(5), FH_W'($urandom));
      send_req(OP_ALLOC, bytes_for_chunks(64), FH_W'($urandom));
      h = pick_live_head();
      while (h >= 0) begin
        send_req(OP_FREE, REQ_W'($urandom), FH_W'(h));
        h = pick_live_head();
      end
    end
  endtask

  // Mostly valid alloc/free traffic with some bad frees and oversize requests
  task automatic test_random_traffic(input int count, input logic [CB_W-1:0] size);
    int h, roll, kind;
    write_chunk_bytes(size);
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      h    = pick_live_head();
      if (roll < 2) drain_results();
      if (roll < 42 && h >= 0) begin
        send_req(OP_FREE, REQ_W'($urandom), FH_W'(h));
      end else if (roll < 48) begin
        send_req(OP_FREE, REQ_W'($urandom), FH_W'($urandom));
      end else begin
        kind = $urandom_range(19);
        if (kind == 0)
          send_req(OP_ALLOC, 19'd0, FH_W'($urandom));
        else if (kind == 1)
          send_req(OP_ALLOC, REQ_W'($urandom), FH_W'($urandom));
        else if (kind == 2)
          send_req(OP_ALLOC, bytes_for_chunks($urandom_range(64, 17)), FH_W'($urandom));
        else
          send_req(OP_ALLOC, bytes_for_chunks($urandom_range(8, 1)), FH_W'($urandom));
      end
    end
  endtask

  initial begin
    // reset held, then released at a falling edge; block then runs its clearing pass
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    src_idle_pct  = 21;
    sink_idle_pct = 77;
    test_directed();
    test_chunk_size_extremes();
    test_random_traffic(260, CB_W'($urandom_range(4096, 1)));

    src_idle_pct  = 77;
    sink_idle_pct = 21;
    test_random_traffic(260, 13'd1);

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    test_random_traffic(260, 13'd8191);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

>>> sim.f
sv/cra_pkg.sv
sv/cra_div.sv
sv/cra_dp.sv
sv/cra_ctrl.sv
sv/chunk_run_allocator_unit.sv
tb/chunk_run_allocator_unit_tb.sv
